FILE: rtl/fern_classifier_counts_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the fern classifier counts core.
// These need a clock named clk and an active-low reset named rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef FERN_CLASSIFIER_COUNTS_CORE_MACROS_SVH
`define FERN_CLASSIFIER_COUNTS_CORE_MACROS_SVH

// Same-cycle implication.
`define FCC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fcc_pkg.sv
// ---------------------------------------------------------------------------
// fcc_pkg
// Shared constants, payload types and helpers of the fern classifier core.
// ---------------------------------------------------------------------------
package fcc_pkg;

  localparam int CODE_BITS   = 13;
  localparam int COUNT_WIDTH = 16;
  localparam int TABLE_DEPTH = 1 << CODE_BITS;
  localparam int ENTRY_W     = 2 * COUNT_WIDTH;
  localparam int TOTAL_W     = COUNT_WIDTH + 1;
  localparam int REM_W       = COUNT_WIDTH + 2;
  localparam int FRAC_BITS   = 16;
  localparam int POST_W      = FRAC_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(POST_W + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REQ_QUERY     = 2'd0;
  localparam logic [1:0] REQ_TRAIN_POS = 2'd1;
  localparam logic [1:0] REQ_TRAIN_NEG = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] first_pixel;
    logic [7:0] second_pixel;
    logic       last_pair;
  } in_item_t;

  typedef struct packed {
    logic [12:0] code_index;
    logic [15:0] positive_count;
    logic [15:0] negative_count;
    logic [16:0] posterior;
  } out_item_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [1:0]           req_type;
  } fern_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

FILE: rtl/fern_classifier_counts_core.sv
// ---------------------------------------------------------------------------
// fern_classifier_counts_core
// Path: after its last pair is accepted, a request passes the queue, the
// table read, the 17-step posterior divider and the output register.
// Throughput: one pair per cycle while in_ready is high; one evaluation at a
// time in the back end, a two-entry queue absorbing short-evaluation bursts.
// Reset: after rst_n is released the table is cleared for 8192 cycles, one
// entry per cycle, and in_ready stays low until that sweep ends.
// ---------------------------------------------------------------------------
module fern_classifier_counts_core import fcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  queue_status_t        q_status;
  logic                 q_push;
  fern_req_t            q_push_data;
  logic                 q_pop;
  fern_req_t            q_pop_data;
  logic                 clearing;
  logic                 ram_wr_en;
  logic [CODE_BITS-1:0] ram_wr_addr;
  logic [ENTRY_W-1:0]   ram_wr_data;
  logic                 ram_rd_en;
  logic [CODE_BITS-1:0] ram_rd_addr;
  logic [ENTRY_W-1:0]   ram_rd_data;

  fcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .clearing    (clearing),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  fcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  fcc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  fcc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_status    (q_status),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: rtl/fcc_ram.sv
// ---------------------------------------------------------------------------
// fcc_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module fcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/fcc_divider.sv
// ---------------------------------------------------------------------------
// fcc_divider
// Restoring divider for the posterior, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fcc_divider import fcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] dividend,
  input  logic [TOTAL_W-1:0]     divisor,
  output logic                   done,
  output logic [POST_W-1:0]      quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [REM_W-1:0]     rem_r;
  logic [TOTAL_W-1:0]   div_r;
  logic [POST_W-1:0]    quo_r;
  logic                 ge;
  logic [REM_W-1:0]     diff;
  logic [REM_W-1:0]     rem_nxt;

  // The dividend is pos shifted up by the fraction width; the first step
  // compares pos itself, each later step brings in one zero bit.
  assign ge      = rem_r >= REM_W'(div_r);
  assign diff    = ge ? rem_r - REM_W'(div_r) : rem_r;
  assign rem_nxt = {diff[REM_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(POST_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(dividend);
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[POST_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = (div_r == '0) ? '0 : quo_r;

endmodule

FILE: rtl/fcc_queue.sv
// ---------------------------------------------------------------------------
// fcc_queue
// Short request queue between the classifying front and the table back.
// ---------------------------------------------------------------------------
module fcc_queue import fcc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fern_req_t     push_data,
  input  logic          pop,
  output fern_req_t     pop_data,
  output queue_status_t status
);

  fern_req_t              mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] cnt_r;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    ptr_inc = (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.full  = cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign status.empty = cnt_r == '0;

endmodule

FILE: rtl/fcc_front.sv
// ---------------------------------------------------------------------------
// fcc_front
// Takes comparison pairs, builds the fern code and queues finished requests.
// ---------------------------------------------------------------------------
module fcc_front import fcc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  input  logic          clearing,
  input  queue_status_t q_status,
  output logic          q_push,
  output fern_req_t     q_push_data
);

  logic [CODE_BITS-1:0] code_r;
  logic [CODE_BITS-1:0] code_nxt;
  logic                 accept;
  logic                 lt;

  assign in_ready = !clearing && !q_status.full;
  assign accept   = in_valid && in_ready;
  assign lt       = in_data.first_pixel < in_data.second_pixel;

  // Older bits shift up and fall off the top once the code is full.
  assign code_nxt = CODE_BITS'({code_r, lt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
    end else if (accept) begin
      code_r <= in_data.last_pair ? '0 : code_nxt;
    end
  end

  assign q_push               = accept && in_data.last_pair;
  assign q_push_data.code     = code_nxt;
  assign q_push_data.req_type = in_data.req_type;

endmodule

FILE: rtl/fcc_back.sv
// ---------------------------------------------------------------------------
// fcc_back
// Clears the count table, then reads, updates and scores queued requests.
// ---------------------------------------------------------------------------
module fcc_back import fcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  queue_status_t        q_status,
  input  fern_req_t            q_data,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 ram_wr_en,
  output logic [CODE_BITS-1:0] ram_wr_addr,
  output logic [ENTRY_W-1:0]   ram_wr_data,
  output logic                 ram_rd_en,
  output logic [CODE_BITS-1:0] ram_rd_addr,
  input  logic [ENTRY_W-1:0]   ram_rd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } back_state_t;

  back_state_t          state_r;
  back_state_t          state_nxt;
  logic [CODE_BITS-1:0] clr_addr_r;
  fern_req_t            req_r;
  logic [COUNT_WIDTH-1:0] pos_r;
  logic [COUNT_WIDTH-1:0] neg_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [COUNT_WIDTH-1:0] cur_pos;
  logic [COUNT_WIDTH-1:0] cur_neg;
  logic [COUNT_WIDTH-1:0] new_pos;
  logic [COUNT_WIDTH-1:0] new_neg;
  logic                 train;
  logic                 div_start;
  logic                 div_done;
  logic [POST_W-1:0]    div_quotient;
  logic                 out_free;
  logic                 out_load;

  assign cur_pos = ram_rd_data[COUNT_WIDTH-1:0];
  assign cur_neg = ram_rd_data[ENTRY_W-1:COUNT_WIDTH];
  assign new_pos = (req_r.req_type == REQ_TRAIN_POS) ? sat_inc(cur_pos) : cur_pos;
  assign new_neg = (req_r.req_type == REQ_TRAIN_NEG) ? sat_inc(cur_neg) : cur_neg;
  assign train   = (req_r.req_type == REQ_TRAIN_POS) || (req_r.req_type == REQ_TRAIN_NEG);

  assign clearing    = state_r == ST_CLEAR;
  assign q_pop       = (state_r == ST_IDLE) && !q_status.empty;
  assign ram_rd_en   = q_pop;
  assign ram_rd_addr = q_data.code;

  assign ram_wr_en   = clearing || ((state_r == ST_READ) && train);
  assign ram_wr_addr = clearing ? clr_addr_r : req_r.code;
  assign ram_wr_data = clearing ? '0 : {new_neg, new_pos};

  assign div_start = state_r == ST_READ;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == ST_OUT) && out_free;

  fcc_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (new_pos),
    .divisor  (TOTAL_W'(new_pos) + TOTAL_W'(new_neg)),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r <= q_data;
    end
    if (state_r == ST_READ) begin
      pos_r <= new_pos;
      neg_r <= new_neg;
    end
    if (out_load) begin
      out_data_r.code_index     <= 13'(req_r.code);
      out_data_r.positive_count <= 16'(pos_r);
      out_data_r.negative_count <= 16'(neg_r);
      out_data_r.posterior      <= 17'(div_quotient);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/fcc_checker.sv
// ---------------------------------------------------------------------------
// fcc_checker
// Port-level checks of the fern classifier core, bound to the top level.
// ---------------------------------------------------------------------------
`include "fern_classifier_counts_core_macros.svh"

module fcc_checker import fcc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result must keep its word.
  `FCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out word changed while stalled")

  // No positive evidence gives a zero posterior.
  `FCC_ASSERT_IMPLY(a_post_zero, out_valid && (out_data.positive_count == 16'd0), out_data.posterior == 17'd0, "posterior not zero without positives")

  // Only positive evidence gives exactly one.
  `FCC_ASSERT_IMPLY(a_post_one, out_valid && (out_data.positive_count != 16'd0) && (out_data.negative_count == 16'd0), out_data.posterior == 17'h10000, "posterior not one without negatives")

  // Mixed evidence lies strictly between zero and one.
  `FCC_ASSERT_IMPLY(a_post_mid, out_valid && (out_data.positive_count != 16'd0) && (out_data.negative_count != 16'd0), (out_data.posterior != 17'd0) && !out_data.posterior[16], "posterior out of range for mixed counts")

endmodule

bind fern_classifier_counts_core fcc_checker u_fcc_checker (.*);

FILE: sim/fern_classifier_counts_checker.sv
// ---------------------------------------------------------------------------
// fern_classifier_counts_checker
// Watches both channels of the fern core, keeps its own copy of the code
// register and of the count tables, and checks every result word field by
// field against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module fern_classifier_counts_checker import fcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int unsigned mismatches,
  output int unsigned awaited,
  output int unsigned scored
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COUNT_WIDTH-1:0] pos_tally [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] neg_tally [TABLE_DEPTH];
  logic [CODE_BITS-1:0]   code_shift;
  out_item_t              fern_results_due [$];

  // Truncated pos / (pos + neg) in Q1.16.
  function automatic logic [16:0] q16_share(input logic [COUNT_WIDTH-1:0] p,
                                            input logic [COUNT_WIDTH-1:0] n);
    logic [63:0] total;
    logic [63:0] scaled;
    total  = 64'(p) + 64'(n);
    scaled = 64'(p) << 16;
    if (total == 0) return '0;
    return 17'(scaled / total);
  endfunction

  always @(posedge clk) begin : scoreboard
    logic [CODE_BITS-1:0] code;
    out_item_t            want;
    int unsigned          bad;
    bad = 0;
    if (!rst_n) begin
      foreach (pos_tally[k]) pos_tally[k] = '0;
      foreach (neg_tally[k]) neg_tally[k] = '0;
      code_shift = '0;
      fern_results_due.delete();
      mismatches <= 0;
      awaited    <= 0;
      scored     <= 0;
    end else begin
      if (in_valid && in_ready) begin
        code = {code_shift[CODE_BITS-2:0], in_data.first_pixel < in_data.second_pixel};
        code_shift = code;
        if (in_data.last_pair) begin
          code_shift = '0;
          case (in_data.req_type)
            REQ_TRAIN_POS: if (pos_tally[code] != '1) pos_tally[code] += 1'b1;
            REQ_TRAIN_NEG: if (neg_tally[code] != '1) neg_tally[code] += 1'b1;
            default: ;
          endcase
          want.code_index     = 13'(code);
          want.positive_count = 16'(pos_tally[code]);
          want.negative_count = 16'(neg_tally[code]);
          want.posterior      = q16_share(pos_tally[code], neg_tally[code]);
          fern_results_due.insert(fern_results_due.size(), want);
        end
      end
      if (out_valid && out_ready) begin
        scored <= scored + 1;
        if (fern_results_due.size() == 0) begin
          $error("result word with no prediction waiting: code_index %0d",
                 out_data.code_index);
          bad = 1;
        end else begin
          want = fern_results_due.pop_front();
          if (out_data.code_index !== want.code_index) begin
            $error("code_index: expected %0d, got %0d", want.code_index,
                   out_data.code_index);
            bad++;
          end
          if (out_data.positive_count !== want.positive_count) begin
            $error("positive_count: expected %0d, got %0d", want.positive_count,
                   out_data.positive_count);
            bad++;
          end
          if (out_data.negative_count !== want.negative_count) begin
            $error("negative_count: expected %0d, got %0d", want.negative_count,
                   out_data.negative_count);
            bad++;
          end
          if (out_data.posterior !== want.posterior) begin
            $error("posterior: expected %0d, got %0d", want.posterior,
                   out_data.posterior);
            bad++;
          end
        end
      end
      mismatches <= mismatches + bad;
      awaited    <= fern_results_due.size();
    end
  end

endmodule

FILE: sim/fern_classifier_counts_core_tb.sv
// ---------------------------------------------------------------------------
// fern_classifier_counts_core_tb
// Drives comparison pairs into the fern core and lets the checker predict
// and compare every result. Covers directed corner words, a run of repeated
// training on one entry, a long receiver hold-off, and random fern
// evaluations aimed at a small pool of codes so that entries build up counts.
// ---------------------------------------------------------------------------
module fern_classifier_counts_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 400_000;
  localparam int unsigned HOLD_CYCLES       = 200;
  localparam int unsigned RANDOM_WORDS      = 1100;
  localparam int unsigned REPEAT_WORDS      = 64;
  localparam int unsigned SETTLE_CYCLES     = 40;
  localparam logic [1:0]  REQ_SPARE         = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int unsigned tx_max_gap   = 4;
  int unsigned rx_max_gap   = 4;
  bit          hold_results = 1'b0;
  int unsigned words_sent   = 0;
  int unsigned mismatches;
  int unsigned awaited;
  int unsigned scored;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fern_classifier_counts_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  fern_classifier_counts_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mismatches(mismatches),
    .awaited   (awaited),
    .scored    (scored)
  );

  // Result side: a random stall before each word, and one long hold-off on request.
  always begin : result_sink
    int unsigned stall;
    if (hold_results) begin
      @(negedge clk);
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_results = 1'b0;
    end
    stall = $urandom_range(rx_max_gap, 0);
    if (stall != 0) begin
      @(negedge clk);
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    @(negedge clk);
    out_ready <= 1'b1;
    do @(posedge clk); while (!(out_valid && out_ready) && !hold_results);
  end

  task automatic send_pair(input logic [1:0] req, input logic [7:0] a,
                           input logic [7:0] b, input logic last);
    int unsigned gap;
    in_item_t    w;
    gap = $urandom_range(tx_max_gap, 0);
    w.req_type     = req;
    w.first_pixel  = a;
    w.second_pixel = b;
    w.last_pair    = last;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Pixel pair whose comparison gives the wanted code bit; ties give a zero.
  function automatic void pixels_for(input bit want_less, output logic [7:0] a,
                                     output logic [7:0] b);
    if (want_less) begin
      a = 8'($urandom_range(254, 0));
      b = 8'($urandom_range(255, a + 1));
    end else begin
      b = 8'($urandom_range(255, 0));
      a = 8'($urandom_range(255, b));
    end
  endfunction

  // One fern evaluation. When aimed, the last CODE_BITS pairs spell out target.
  task automatic run_evaluation(input int unsigned pairs,
                                input logic [CODE_BITS-1:0] target,
                                input bit aimed, input logic [1:0] req);
    int unsigned bit_pos;
    logic [7:0]  a;
    logic [7:0]  b;
    for (int unsigned i = 0; i < pairs; i++) begin
      bit_pos = pairs - 1 - i;
      if (aimed && bit_pos < CODE_BITS) begin
        pixels_for(target[bit_pos], a, b);
      end else begin
        a = 8'($urandom);
        b = 8'($urandom);
      end
      if (i == pairs - 1) send_pair(req, a, b, 1'b1);
      else send_pair(2'($urandom), a, b, 1'b0);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  function automatic logic [1:0] random_request();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r < 3) return REQ_QUERY;
    if (r < 6) return REQ_TRAIN_POS;
    if (r < 9) return REQ_TRAIN_NEG;
    return REQ_SPARE;
  endfunction

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results still awaited.", CYCLE_LIMIT, awaited);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [CODE_BITS-1:0] pool [8];
    logic [CODE_BITS-1:0] target;
    logic [7:0]           a;
    logic [7:0]           b;
    int unsigned          roll;
    int unsigned          random_start;
    foreach (pool[k]) pool[k] = CODE_BITS'($urandom);
    pool[0] = '1;
    pool[1] = CODE_BITS'(1);
    pool[2] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words. An untouched entry reports a zero posterior.
    send_pair(REQ_QUERY, 8'd0, 8'd0, 1'b1);
    send_pair(REQ_TRAIN_POS, 8'd0, 8'd255, 1'b1);
    send_pair(REQ_TRAIN_NEG, 8'd254, 8'd255, 1'b1);
    send_pair(REQ_SPARE, 8'd127, 8'd128, 1'b1);
    for (int i = 0; i < CODE_BITS; i++)
      send_pair((i == CODE_BITS - 1) ? REQ_TRAIN_POS : REQ_SPARE, 8'd0, 8'd255,
                i == CODE_BITS - 1);
    // Short evaluations: the code holds only the pairs seen.
    send_pair(REQ_QUERY, 8'd1, 8'd2, 1'b0);
    send_pair(REQ_QUERY, 8'd255, 8'd255, 1'b0);
    send_pair(REQ_TRAIN_NEG, 8'd128, 8'd255, 1'b1);
    send_pair(REQ_TRAIN_POS, 8'd255, 8'd0, 1'b0);
    send_pair(REQ_TRAIN_POS, 8'd0, 8'd1, 1'b0);
    send_pair(REQ_TRAIN_POS, 8'd200, 8'd100, 1'b0);
    send_pair(REQ_QUERY, 8'd10, 8'd11, 1'b1);

    // Train the positive count of code one over and over, back to back.
    drain_results();
    tx_max_gap = 0;
    repeat (REPEAT_WORDS) begin
      pixels_for(1'b1, a, b);
      send_pair(REQ_TRAIN_POS, a, b, 1'b1);
    end
    send_pair(REQ_TRAIN_NEG, 8'd3, 8'd4, 1'b1);
    send_pair(REQ_TRAIN_NEG, 8'd0, 8'd255, 1'b1);
    send_pair(REQ_SPARE, 8'd254, 8'd255, 1'b1);

    // Hold the result side off while short evaluations keep coming.
    drain_results();
    hold_results = 1'b1;
    repeat (16) run_evaluation(1, '0, 1'b0, random_request());
    tx_max_gap = 4;

    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      if ($urandom_range(7, 0) == 0) begin
        tx_max_gap = 4 * $urandom_range(1, 0);
        rx_max_gap = 4 * $urandom_range(1, 0);
      end
      roll   = $urandom_range(99, 0);
      target = pool[$urandom_range(7, 0)];
      if (roll < 60) run_evaluation(CODE_BITS, target, 1'b1, random_request());
      else if (roll < 72) run_evaluation(CODE_BITS, '0, 1'b0, random_request());
      else if (roll < 87)
        run_evaluation($urandom_range(CODE_BITS - 1, 1), target, 1'b1, random_request());
      else
        run_evaluation($urandom_range(CODE_BITS + 7, CODE_BITS + 1), target, 1'b1,
                       random_request());
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run sent %0d pair words and checked %0d result words, including %0d",
             words_sent, scored, REPEAT_WORDS);
    $display("training words on one entry and a %0d-cycle result hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
